### design/fba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fba_pkg - shared definitions for the fit block allocator
// Sizes, widths, policy and register codes, and the types passed between the
// scan sequencer and the fit compare unit.
// ----------------------------------------------------------------------------
package fba_pkg;

    // Table geometry
    localparam int NUM_BLOCKS = 16;
    localparam int SIZE_BITS  = 16;
    localparam int IDX_BITS   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int LIM_BITS   = $clog2(NUM_BLOCKS + 1);

    // Port field widths
    localparam int FUNC_BITS       = 1;
    localparam int BLK_IDX_BITS    = 4;
    localparam int SIZE_FIELD_BITS = 16;
    localparam int POLICY_BITS     = 2;
    localparam int COUNT_BITS      = 5;
    localparam int CFG_INDEX_BITS  = 1;
    localparam int CFG_DATA_BITS   = 5;

    // Input word function codes
    localparam logic [FUNC_BITS-1:0] FUNC_LOAD  = 1'b0;
    localparam logic [FUNC_BITS-1:0] FUNC_ALLOC = 1'b1;

    // Fit policy codes; the spare code behaves as first fit
    localparam logic [POLICY_BITS-1:0] POLICY_FIRST = 2'd0;
    localparam logic [POLICY_BITS-1:0] POLICY_BEST  = 2'd1;
    localparam logic [POLICY_BITS-1:0] POLICY_WORST = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_FIT_POLICY  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BLOCK_COUNT = 1'b1;

    // Register reset values
    localparam logic [POLICY_BITS-1:0] POLICY_RESET = POLICY_FIRST;
    localparam logic [COUNT_BITS-1:0]  COUNT_RESET  = 5'd16;

    // One candidate block presented to the compare unit
    typedef struct packed {
        logic                 vld;
        logic                 used;
        logic [SIZE_BITS-1:0] size;
    } fit_cand_t;

    // Decision returned by the compare unit
    typedef struct packed {
        logic take;   // candidate becomes the current pick
        logic stop;   // no later block can change the pick
    } fit_sel_t;

endpackage

### design/fit_block_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fit_block_allocator_core - fixed-partition first/best/worst fit allocator
// Size table with per-block used flags, scanned one block per cycle.
// ----------------------------------------------------------------------------
// A load word (func = 0) writes one block size, gives no result and leaves
// the block ready for the next word. A request word (func = 1) scans blocks
// 0 to limit-1, where limit is block_count capped at the table depth, one
// block per cycle through the size RAM's registered read port and the shared
// fit compare unit. A request keeps the block busy through the scan and until
// out_ready takes the result word, and in_ready is low throughout. First fit
// ends the scan at the first adequate free block. The granted block is marked
// used when its result word is taken; a request with end_of_run set frees
// every block at that point. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module fit_block_allocator_core (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration
    input  logic                               cfg_we,
    input  logic [fba_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [fba_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    // input channel
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [fba_pkg::FUNC_BITS-1:0]      func,
    input  logic [fba_pkg::BLK_IDX_BITS-1:0]   block_index,
    input  logic [fba_pkg::SIZE_FIELD_BITS-1:0] size,
    input  logic                               end_of_run,
    // result channel
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               granted,
    output logic [fba_pkg::BLK_IDX_BITS-1:0]   alloc_index
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } state_t;

    state_t                              state_reg, state_next;
    logic [fba_pkg::POLICY_BITS-1:0]     policy_reg;
    logic [fba_pkg::COUNT_BITS-1:0]      count_reg;
    logic [fba_pkg::LIM_BITS-1:0]        limit_reg, limit_next;
    logic [fba_pkg::LIM_BITS-1:0]        ptr_reg, ptr_next;
    logic                                cmp_vld_reg, cmp_vld_next;
    logic [fba_pkg::IDX_BITS-1:0]        cmp_idx_reg, cmp_idx_next;
    logic                                found_reg, found_next;
    logic [fba_pkg::IDX_BITS-1:0]        pick_reg, pick_next;
    logic [fba_pkg::SIZE_BITS-1:0]       best_reg, best_next;
    logic [fba_pkg::SIZE_BITS-1:0]       req_size_reg, req_size_next;
    logic                                eor_reg, eor_next;
    logic [fba_pkg::NUM_BLOCKS-1:0]      used_reg, used_next;
    logic [fba_pkg::SIZE_BITS-1:0]       rd_data_reg;

    logic [fba_pkg::SIZE_BITS-1:0]       size_mem [fba_pkg::NUM_BLOCKS];
    logic                                mem_we;
    logic [fba_pkg::IDX_BITS-1:0]        mem_wr_addr;
    logic [fba_pkg::IDX_BITS-1:0]        rd_addr;
    logic                                load_in_range;
    logic [fba_pkg::LIM_BITS-1:0]        limit_cap;

    fba_pkg::fit_cand_t                  cand;
    fba_pkg::fit_sel_t                   sel;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= fba_pkg::POLICY_RESET;
            count_reg  <= fba_pkg::COUNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fba_pkg::REG_FIT_POLICY:
                    policy_reg <= cfg_data[fba_pkg::POLICY_BITS-1:0];
                fba_pkg::REG_BLOCK_COUNT:
                    count_reg <= cfg_data[fba_pkg::COUNT_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // scan length, capped at the table depth
    assign limit_cap = (int'(count_reg) > fba_pkg::NUM_BLOCKS) ?
                       fba_pkg::LIM_BITS'(fba_pkg::NUM_BLOCKS) :
                       fba_pkg::LIM_BITS'(count_reg);

    assign load_in_range = int'(block_index) < fba_pkg::NUM_BLOCKS;
    assign mem_wr_addr   = fba_pkg::IDX_BITS'(block_index);
    assign rd_addr       = ptr_reg[fba_pkg::IDX_BITS-1:0];

    // size table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            size_mem[mem_wr_addr] <= fba_pkg::SIZE_BITS'(size);
        end
        rd_data_reg <= size_mem[rd_addr];
    end

    // candidate fetched last cycle
    assign cand.vld  = cmp_vld_reg;
    assign cand.used = used_reg[cmp_idx_reg];
    assign cand.size = rd_data_reg;

    fba_fit_unit u_fit (
        .policy    (policy_reg),
        .req_size  (req_size_reg),
        .found     (found_reg),
        .best_size (best_reg),
        .cand      (cand),
        .sel       (sel)
    );

    // sequencer next state
    always_comb
    begin
        state_next    = state_reg;
        limit_next    = limit_reg;
        ptr_next      = ptr_reg;
        cmp_vld_next  = 1'b0;
        cmp_idx_next  = cmp_idx_reg;
        found_next    = found_reg;
        pick_next     = pick_reg;
        best_next     = best_reg;
        req_size_next = req_size_reg;
        eor_next      = eor_reg;
        used_next     = used_reg;
        mem_we        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (func == fba_pkg::FUNC_LOAD)
                    begin
                        mem_we = load_in_range;
                    end
                    else
                    begin
                        req_size_next = fba_pkg::SIZE_BITS'(size);
                        eor_next      = end_of_run;
                        limit_next    = limit_cap;
                        ptr_next      = '0;
                        found_next    = 1'b0;
                        pick_next     = '0;
                        best_next     = '0;
                        state_next    = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                // fold in the candidate under compare
                if (sel.take)
                begin
                    found_next = 1'b1;
                    pick_next  = cmp_idx_reg;
                    best_next  = rd_data_reg;
                end
                // fetch the next block or finish
                if (sel.stop || (ptr_reg == limit_reg))
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = ptr_reg[fba_pkg::IDX_BITS-1:0];
                    ptr_next     = ptr_reg + fba_pkg::LIM_BITS'(1);
                end
            end
            ST_RESULT:
            begin
                if (out_ready)
                begin
                    if (found_reg)
                    begin
                        used_next[pick_reg] = 1'b1;
                    end
                    if (eor_reg)
                    begin
                        used_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer state and scan registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            ptr_reg     <= '0;
            limit_reg   <= '0;
            cmp_vld_reg <= 1'b0;
            found_reg   <= 1'b0;
            pick_reg    <= '0;
            eor_reg     <= 1'b0;
            used_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            ptr_reg     <= ptr_next;
            limit_reg   <= limit_next;
            cmp_vld_reg <= cmp_vld_next;
            found_reg   <= found_next;
            pick_reg    <= pick_next;
            eor_reg     <= eor_next;
            used_reg    <= used_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmp_idx_reg  <= cmp_idx_next;
        best_reg     <= best_next;
        req_size_reg <= req_size_next;
    end

    // handshake and result word
    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = (state_reg == ST_RESULT);
    assign granted     = found_reg;
    assign alloc_index = found_reg ? fba_pkg::BLK_IDX_BITS'(pick_reg) : '0;

    // checks
    a_pick_was_free: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && granted) |-> !used_reg[pick_reg])
        else $error("granted block already marked used");

    a_pick_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && granted) |-> (fba_pkg::LIM_BITS'(pick_reg) < limit_reg))
        else $error("granted block outside scan range");

    a_run_end_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && eor_reg) |=> (used_reg == '0))
        else $error("end of run left blocks in use");

    a_ptr_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (ptr_reg <= limit_reg))
        else $error("scan pointer ran past limit");

    a_used_steady: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && out_ready) |=> $stable(used_reg))
        else $error("used flags changed outside result handshake");

endmodule

### design/fba_fit_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fba_fit_unit - shared fit compare unit
// Judges one candidate block per cycle against the request and the current
// pick, under the configured fit policy.
// ----------------------------------------------------------------------------
module fba_fit_unit (
    input  logic [fba_pkg::POLICY_BITS-1:0] policy,
    input  logic [fba_pkg::SIZE_BITS-1:0]   req_size,
    input  logic                            found,
    input  logic [fba_pkg::SIZE_BITS-1:0]   best_size,
    input  fba_pkg::fit_cand_t              cand,
    output fba_pkg::fit_sel_t               sel
);

    logic fits;
    logic smaller;
    logic larger;

    // size compares
    assign fits    = cand.vld && !cand.used && (cand.size >= req_size);
    assign smaller = cand.size < best_size;
    assign larger  = cand.size > best_size;

    // policy selection; ties keep the earlier block
    always_comb
    begin
        sel.take = 1'b0;
        sel.stop = 1'b0;
        if (fits)
        begin
            if (!found)
            begin
                sel.take = 1'b1;
                sel.stop = (policy != fba_pkg::POLICY_BEST) &&
                           (policy != fba_pkg::POLICY_WORST);
            end
            else if (policy == fba_pkg::POLICY_BEST)
            begin
                sel.take = smaller;
            end
            else if (policy == fba_pkg::POLICY_WORST)
            begin
                sel.take = larger;
            end
        end
    end

endmodule
